// ===== hw/rtl/linear_probe_hash_table_defines.svh =====
// Assertion macros for the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge out of reset.
`define LPHT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lpht: property violated");
// A condition that must hold in the cycle after its trigger.
`define LPHT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpht: next-cycle property violated");
`else
`define LPHT_ASSERT(name, clk, rst_n, prop)
`define LPHT_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/lpht_pkg.sv =====
package lpht_pkg;

    // Default sizing.
    localparam int SLOTS_DEF       = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Operation codes.
    localparam logic [2:0] OP_FIND  = 3'd0;
    localparam logic [2:0] OP_PUT   = 3'd1;
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_ERASE = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    // Result status codes.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_DUP  = 2'd2;
    localparam logic [1:0] STAT_FULL = 2'd3;

    // Slot tags.
    localparam logic [1:0] TAG_EMPTY = 2'd0;
    localparam logic [1:0] TAG_LIVE  = 2'd1;
    localparam logic [1:0] TAG_TOMB  = 2'd2;

    // Control sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/lpht_if.sv =====
// Request channel: one table operation per word.
interface lpht_req_if;
    import lpht_pkg::*;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [63:0] key_word;
    logic [3:0]  key_bytes;
    logic [31:0] key_hash;
    logic [31:0] store_value;

    modport source (output valid, operation, key_word, key_bytes, key_hash, store_value,
                    input ready);
    modport sink   (input valid, operation, key_word, key_bytes, key_hash, store_value,
                    output ready);
endinterface

// Response channel: one result word per operation.
interface lpht_rsp_if;
    import lpht_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        found;
    logic [31:0] read_value;
    logic [5:0]  slot_index;
    logic [6:0]  live_count;

    modport source (output valid, status, found, read_value, slot_index, live_count,
                    input ready);
    modport sink   (input valid, status, found, read_value, slot_index, live_count,
                    output ready);
endinterface

// Configuration write channel for the mode register.
interface lpht_cfg_if;
    import lpht_pkg::*;
    logic valid;
    logic ready;
    logic map_mode;

    modport source (output valid, map_mode, input ready);
    modport sink   (input valid, map_mode, output ready);
endinterface

// ===== hw/rtl/lpht_ram.sv =====
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/linear_probe_hash_table.sv =====
// Find/put/add/erase go from idle through home-slot reduction (when SLOTS is not a power
// of two) into the probe walk and then to done; a refused store goes from idle to done.
// One operation at a time; the probe walk reads one slot per cycle from the slot memory,
// which has one write port and one registered read port.
// Clear writes every slot empty in turn. After reset a pass empties every slot
// before the first request word is accepted; configuration writes are taken throughout.
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table #(
    parameter int SLOTS       = lpht_pkg::SLOTS_DEF,
    parameter int VALUE_WIDTH = lpht_pkg::VALUE_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpht_cfg_if.sink   i_cfg,
    lpht_req_if.sink   i_req,
    lpht_rsp_if.source o_rsp
);
    import lpht_pkg::*;

    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int VW    = VALUE_WIDTH;
    localparam int EW    = 2 + 64 + 4 + 32 + VW;
    localparam bit POW2  = (SLOTS & (SLOTS - 1)) == 0;
    localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

    // Control state.
    t_state          r_state, n_state;
    logic            r_map_mode;
    logic [CW-1:0]   r_entry, n_entry;
    logic [CW-1:0]   r_tomb, n_tomb;
    logic            r_clr_op, n_clr_op;

    // Operation in flight.
    logic [2:0]      r_op, n_op;
    logic [63:0]     r_key, n_key;
    logic [3:0]      r_len, n_len;
    logic [31:0]     r_hash, n_hash;
    logic [VW-1:0]   r_val, n_val;
    logic            r_full, n_full;

    // Probe walk.
    logic [SW-1:0]   r_idx, n_idx;
    logic [SW-1:0]   r_home, n_home;
    logic [SW-1:0]   r_cnt, n_cnt;
    logic            r_tomb_vld, n_tomb_vld;
    logic [SW-1:0]   r_tomb_idx, n_tomb_idx;
    logic            r_hit, n_hit;
    logic            r_empty, n_empty;
    logic [VW-1:0]   r_rd_val, n_rd_val;

    // Home-slot reduction.
    logic [31:0]     r_hsh, n_hsh;
    logic [SW-1:0]   r_rem, n_rem;
    logic [2:0]      r_mstep, n_mstep;

    // Response register.
    logic            r_out_valid, n_out_valid;
    logic [1:0]      r_out_status, n_out_status;
    logic            r_out_found, n_out_found;
    logic [31:0]     r_out_rd, n_out_rd;
    logic [5:0]      r_out_slot, n_out_slot;
    logic [6:0]      r_out_live, n_out_live;

    // Slot memory ports.
    logic            ram_we;
    logic [SW-1:0]   ram_waddr;
    logic [EW-1:0]   ram_wdata;
    logic [SW-1:0]   ram_raddr;
    logic [EW-1:0]   ram_rdata;
    logic [1:0]      wtag;

    // Slot fields from the read word.
    logic [1:0]      rd_tag;
    logic [63:0]     rd_key;
    logic [3:0]      rd_len;
    logic [31:0]     rd_hash;
    logic [VW-1:0]   rd_val;

    // Request decode.
    logic            accept;
    logic [3:0]      len_c;
    logic [63:0]     key_m;
    logic [CW+2:0]   fill4;
    logic            store_full;
    logic [SW-1:0]   nxt_idx;
    logic [SW-1:0]   rem_step;
    logic [SW:0]     rem_t;
    logic [SW-1:0]   res_slot;
    logic [CW:0]     count_sum;

    lpht_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_tag  = ram_rdata[EW-1 -: 2];
    assign rd_key  = ram_rdata[EW-3 -: 64];
    assign rd_len  = ram_rdata[VW+35 -: 4];
    assign rd_hash = ram_rdata[VW+31 -: 32];
    assign rd_val  = ram_rdata[VW-1:0];

    assign ram_wdata = {wtag, r_key, r_len, r_hash, r_val};

    // Configuration register, always ready.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_mode <= 1'b1;
        end else if (i_cfg.valid) begin
            r_map_mode <= i_cfg.map_mode;
        end
    end

    // Key length clamp and byte masking.
    always_comb begin
        len_c = (i_req.key_bytes > 4'd8) ? 4'd8 : i_req.key_bytes;
        for (int b = 0; b < 8; b++) begin
            key_m[8*b +: 8] = (4'(b) < len_c) ? i_req.key_word[8*b +: 8] : 8'h00;
        end
    end

    // Load check: stores are refused at three quarters of capacity.
    assign fill4      = ({3'b000, r_entry} + {3'b000, r_tomb} + (CW+3)'(1)) << 2;
    assign store_full = fill4 >= (CW+3)'(3 * SLOTS);

    assign nxt_idx = (r_idx == LAST) ? '0 : r_idx + SW'(1);
    assign accept  = i_req.valid && i_req.ready;

    // Four bits of the hash modulo SLOTS per cycle, most significant first.
    always_comb begin
        rem_step = r_rem;
        rem_t    = '0;
        for (int k = 0; k < 4; k++) begin
            rem_t = {rem_step, r_hsh[31-k]};
            if (rem_t >= (SW+1)'(SLOTS)) begin
                rem_t = rem_t - (SW+1)'(SLOTS);
            end
            rem_step = rem_t[SW-1:0];
        end
    end

    // Sequencer: next state, memory control and results.
    always_comb begin
        n_state      = r_state;
        n_entry      = r_entry;
        n_tomb       = r_tomb;
        n_clr_op     = r_clr_op;
        n_op         = r_op;
        n_key        = r_key;
        n_len        = r_len;
        n_hash       = r_hash;
        n_val        = r_val;
        n_full       = r_full;
        n_idx        = r_idx;
        n_home       = r_home;
        n_cnt        = r_cnt;
        n_tomb_vld   = r_tomb_vld;
        n_tomb_idx   = r_tomb_idx;
        n_hit        = r_hit;
        n_empty      = r_empty;
        n_rd_val     = r_rd_val;
        n_hsh        = r_hsh;
        n_rem        = r_rem;
        n_mstep      = r_mstep;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_rd     = r_out_rd;
        n_out_slot   = r_out_slot;
        n_out_live   = r_out_live;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_raddr    = r_idx;
        wtag         = TAG_LIVE;
        res_slot     = '0;
        i_req.ready  = 1'b0;

        // The response register empties when the word is taken.
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                wtag   = TAG_EMPTY;
                if (r_idx == LAST) begin
                    n_entry = '0;
                    n_tomb  = '0;
                    n_idx   = '0;
                    n_state = r_clr_op ? S_DONE : S_IDLE;
                end else begin
                    n_idx = r_idx + SW'(1);
                end
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (accept) begin
                    n_op       = i_req.operation;
                    n_key      = key_m;
                    n_len      = len_c;
                    n_hash     = i_req.key_hash;
                    n_val      = r_map_mode ? VW'(64'(i_req.store_value)) : '0;
                    n_full     = 1'b0;
                    n_cnt      = '0;
                    n_tomb_vld = 1'b0;
                    n_hit      = 1'b0;
                    n_empty    = 1'b0;
                    n_rd_val   = '0;
                    n_hsh      = i_req.key_hash;
                    n_rem      = '0;
                    n_mstep    = '0;
                    unique case (i_req.operation)
                        OP_FIND, OP_PUT, OP_ADD, OP_ERASE: begin
                            if ((i_req.operation == OP_PUT || i_req.operation == OP_ADD)
                                && store_full) begin
                                n_full  = 1'b1;
                                n_state = S_DONE;
                            end else if (POW2) begin
                                ram_raddr = i_req.key_hash[SW-1:0];
                                n_idx     = i_req.key_hash[SW-1:0];
                                n_home    = i_req.key_hash[SW-1:0];
                                n_state   = S_PROBE;
                            end else begin
                                n_state = S_HASH;
                            end
                        end
                        OP_CLEAR: begin
                            n_idx    = '0;
                            n_clr_op = 1'b1;
                            n_state  = S_CLEAR;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_HASH: begin
                n_rem   = rem_step;
                n_hsh   = r_hsh << 4;
                n_mstep = r_mstep + 3'd1;
                if (r_mstep == 3'd7) begin
                    ram_raddr = rem_step;
                    n_idx     = rem_step;
                    n_home    = rem_step;
                    n_state   = S_PROBE;
                end
            end
            S_PROBE: begin
                // The word for r_idx is on the read port; decide and fetch the next slot.
                if (rd_tag == TAG_EMPTY) begin
                    n_empty = 1'b1;
                    n_state = S_DONE;
                end else if (rd_tag == TAG_LIVE && rd_hash == r_hash && rd_len == r_len
                             && rd_key == r_key) begin
                    n_hit    = 1'b1;
                    n_rd_val = rd_val;
                    n_state  = S_DONE;
                end else begin
                    if (rd_tag == TAG_TOMB && !r_tomb_vld) begin
                        n_tomb_vld = 1'b1;
                        n_tomb_idx = r_idx;
                    end
                    if (r_cnt == LAST) begin
                        n_idx   = r_home;
                        n_state = S_DONE;
                    end else begin
                        ram_raddr = nxt_idx;
                        n_idx     = nxt_idx;
                        n_cnt     = r_cnt + SW'(1);
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_status = STAT_OK;
                    n_out_found  = 1'b0;
                    n_out_rd     = '0;
                    unique case (r_op)
                        OP_FIND, OP_ERASE: begin
                            res_slot = r_idx;
                            if (r_hit) begin
                                n_out_found = 1'b1;
                                n_out_rd    = r_map_mode ? 32'(64'(r_rd_val)) : '0;
                                if (r_op == OP_ERASE) begin
                                    ram_we  = 1'b1;
                                    wtag    = TAG_TOMB;
                                    n_entry = r_entry - CW'(1);
                                    n_tomb  = r_tomb + CW'(1);
                                end
                            end else begin
                                n_out_status = STAT_MISS;
                            end
                        end
                        OP_PUT, OP_ADD: begin
                            priority if (r_full) begin
                                n_out_status = STAT_FULL;
                            end else if (r_hit) begin
                                res_slot = r_idx;
                                if (r_op == OP_ADD) begin
                                    n_out_status = STAT_DUP;
                                end else begin
                                    ram_we = 1'b1;
                                end
                            end else if (r_tomb_vld) begin
                                // Reuse the first tombstone passed on the walk.
                                ram_we    = 1'b1;
                                ram_waddr = r_tomb_idx;
                                res_slot  = r_tomb_idx;
                                n_tomb    = r_tomb - CW'(1);
                                n_entry   = r_entry + CW'(1);
                            end else if (!r_empty) begin
                                n_out_status = STAT_FULL;
                            end else begin
                                ram_we   = 1'b1;
                                res_slot = r_idx;
                                n_entry  = r_entry + CW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out_slot  = 6'(32'(res_slot));
                    n_out_live  = 7'(32'(n_entry));
                    n_out_valid = 1'b1;
                    n_clr_op    = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_entry     <= '0;
            r_tomb      <= '0;
            r_clr_op    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_entry     <= n_entry;
            r_tomb      <= n_tomb;
            r_clr_op    <= n_clr_op;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_len        <= n_len;
        r_hash       <= n_hash;
        r_val        <= n_val;
        r_full       <= n_full;
        r_home       <= n_home;
        r_cnt        <= n_cnt;
        r_tomb_vld   <= n_tomb_vld;
        r_tomb_idx   <= n_tomb_idx;
        r_hit        <= n_hit;
        r_empty      <= n_empty;
        r_rd_val     <= n_rd_val;
        r_hsh        <= n_hsh;
        r_rem        <= n_rem;
        r_mstep      <= n_mstep;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_rd     <= n_out_rd;
        r_out_slot   <= n_out_slot;
        r_out_live   <= n_out_live;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.found      = r_out_found;
    assign o_rsp.read_value = r_out_rd;
    assign o_rsp.slot_index = r_out_slot;
    assign o_rsp.live_count = r_out_live;

    assign count_sum = {1'b0, r_entry} + {1'b0, r_tomb};

    // Live plus tombstone entries never exceed the slot count.
    `LPHT_ASSERT(a_count_bound, i_clk, i_rst_n, count_sum <= (CW+1)'(SLOTS))
    // Only one operation is in flight at a time.
    `LPHT_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, accept, !i_req.ready)
    // The probe walk only reads the slot memory.
    `LPHT_ASSERT(a_probe_read_only, i_clk, i_rst_n, (r_state == S_PROBE) |-> !ram_we)

endmodule
